// File: rtl/cfcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfcc_pkg
// Types, constants and the byte-wise CRC step shared by the frame codec.
// ----------------------------------------------------------------------------
package cfcc_pkg;

  localparam logic [7:0] CRC_START = 8'h82;
  localparam logic [7:0] CRC_POLY  = 8'h8C;

  localparam int FRAME_BYTES = 4;

  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] REG_DEVICE_ADDRESS = 2'd0;

  localparam logic MODE_BUILD = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  command_code;
    logic [15:0] command_value;
    logic [7:0]  resp_byte0;
    logic [7:0]  resp_byte1;
    logic [7:0]  resp_crc;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  frame_byte0;
    logic [7:0]  frame_byte1;
    logic [7:0]  frame_byte2;
    logic [7:0]  frame_crc;
    logic [15:0] read_value;
    logic        read_ok;
  } out_item_t;

  typedef logic [FRAME_BYTES-1:0][7:0] crc_msg_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/command_frame_crc8_codec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// command_frame_crc8_codec
// Builds CRC-8 protected command frames and checks response frames.
//
//   Channel   Direction  Handshake              Payload
//   in        in         in_valid / in_stall    in_item_t
//   out       out        out_valid / out_stall  out_item_t
//   config    in         APB-style, pready = 1  device_address at byte 0
//
// Each beat passes through an input register and then a result register,
// which drives the output. One beat is taken every cycle while the output
// is not stalled; the throughput is set by the single CRC network between
// the two registers. Reset clears both valid flags and the device address.
// A stalled output holds its beat, and the input stalls only once both
// registers are full.
// ----------------------------------------------------------------------------
module command_frame_crc8_codec
  import cfcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic       [7:0] device_address;
  in_item_t         item;
  logic             item_valid;
  out_item_t        result_next;
  logic             out_load;
  logic             in_take;

  cfcc_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .device_address (device_address)
  );

  cfcc_frame u_frame (
    .item           (item),
    .device_address (device_address),
    .result         (result_next)
  );

  assign out_load = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !out_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (out_load) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result_next;
    end
  end

  a_take_fills_input: assert property (@(posedge clk) disable iff (rst)
    in_take |=> item_valid)
    else $error("accepted beat did not reach the input register");

  a_load_fills_output: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result register not filled after a load");

  a_check_clears_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_ok |-> out_data.frame_crc == 8'd0 && out_data.frame_byte0 == 8'd0)
    else $error("check result carries frame bytes");

  a_fail_clears_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.read_ok |-> out_data.read_value == 16'd0)
    else $error("failed or build result carries a read value");

  a_address_written: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr == REG_DEVICE_ADDRESS
      |=> device_address == $past(pwdata[7:0]))
    else $error("device address write lost");

endmodule
`default_nettype wire

// File: rtl/cfcc_crc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfcc_crc
// Reflected CRC-8 over a four-byte message, byte zero first.
// ----------------------------------------------------------------------------
module cfcc_crc
  import cfcc_pkg::*;
(
  input  crc_msg_t   msg,
  output logic [7:0] crc
);

  logic [FRAME_BYTES:0][7:0] acc;

  assign acc[0] = CRC_START;

  for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_byte
    assign acc[i+1] = crc8_byte(acc[i], msg[i]);
  end

  assign crc = acc[FRAME_BYTES];

endmodule
`default_nettype wire

// File: rtl/cfcc_frame.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfcc_frame
// Builds a command frame or checks a response, sharing one CRC network.
// ----------------------------------------------------------------------------
module cfcc_frame
  import cfcc_pkg::*;
(
  input  in_item_t   item,
  input  logic [7:0] device_address,
  output out_item_t  result
);

  crc_msg_t   msg;
  logic [7:0] crc;

  always_comb begin
    msg[0] = device_address;
    if (item.mode == MODE_CHECK) begin
      msg[1] = item.resp_byte0;
      msg[2] = item.resp_byte1;
      msg[3] = item.resp_crc;
    end else begin
      msg[1] = item.command_code;
      msg[2] = item.command_value[7:0];
      msg[3] = item.command_value[15:8];
    end
  end

  cfcc_crc u_crc (
    .msg (msg),
    .crc (crc)
  );

  always_comb begin
    result = '0;
    if (item.mode == MODE_BUILD) begin
      result.frame_byte0 = item.command_code;
      result.frame_byte1 = item.command_value[7:0];
      result.frame_byte2 = item.command_value[15:8];
      result.frame_crc   = crc;
    end else if (crc == 8'd0) begin
      result.read_value = {item.resp_byte1, item.resp_byte0};
      result.read_ok    = 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cfcc_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfcc_regs
// APB-style register file holding the partner device address.
// ----------------------------------------------------------------------------
module cfcc_regs
  import cfcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [7:0]        device_address
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == REG_DEVICE_ADDRESS);

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd0;
    end else if (wr_en) begin
      device_address <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == REG_DEVICE_ADDRESS) begin
      prdata = {24'd0, device_address};
    end
  end

endmodule
`default_nettype wire

// File: tb/command_frame_crc8_codec_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_crc8_codec_tb
// Self-checking bench for the CRC-8 command frame codec. Build beats and
// response beats, well-formed and corrupted, run through both channels under
// several idle and stall mixes and several partner addresses. Every result
// beat is compared field by field with a local prediction of the frame.
// ----------------------------------------------------------------------------
module command_frame_crc8_codec_tb;
  import cfcc_pkg::*;

  localparam logic [7:0] CRC_SEED    = 8'h82;
  localparam logic [7:0] CRC_TAPS    = 8'h8C;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         PHASE_BEATS = 470;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  in_item_t  pending_beats[$];
  out_item_t expected_frames[$];
  logic [7:0] partner_addr = 8'h00;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int failures = 0;
  int quiet_cycles = 0;

  command_frame_crc8_codec i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ data[i];
      acc = {1'b0, acc[7:1]};
      if (fb) begin
        acc = acc ^ CRC_TAPS;
      end
    end
    return acc;
  endfunction

  function automatic logic [7:0] response_crc(input logic [7:0] addr, input logic [7:0] b0,
                                              input logic [7:0] b1);
    return crc8_fold(crc8_fold(crc8_fold(CRC_SEED, addr), b0), b1);
  endfunction

  function automatic out_item_t predict_frame(input in_item_t beat, input logic [7:0] addr);
    out_item_t  frame;
    logic [7:0] crc;
    frame = '0;
    if (beat.mode == MODE_BUILD) begin
      frame.frame_byte0 = beat.command_code;
      frame.frame_byte1 = beat.command_value[7:0];
      frame.frame_byte2 = beat.command_value[15:8];
      crc = crc8_fold(CRC_SEED, addr);
      crc = crc8_fold(crc, beat.command_code);
      crc = crc8_fold(crc, beat.command_value[7:0]);
      frame.frame_crc = crc8_fold(crc, beat.command_value[15:8]);
    end else begin
      crc = crc8_fold(response_crc(addr, beat.resp_byte0, beat.resp_byte1), beat.resp_crc);
      if (crc == 8'h00) begin
        frame.read_value = {beat.resp_byte1, beat.resp_byte0};
        frame.read_ok    = 1'b1;
      end
    end
    return frame;
  endfunction

  function automatic in_item_t make_beat(input logic mode, input logic [7:0] cmd,
                                         input logic [15:0] value, input logic [7:0] b0,
                                         input logic [7:0] b1, input logic [7:0] crc);
    in_item_t beat;
    beat.mode          = mode;
    beat.command_code  = cmd;
    beat.command_value = value;
    beat.resp_byte0    = b0;
    beat.resp_byte1    = b1;
    beat.resp_crc      = crc;
    return beat;
  endfunction

  function automatic in_item_t random_beat(input logic [7:0] addr);
    in_item_t beat;
    int       pick;
    int       flip;
    beat = make_beat(1'($urandom_range(1)), 8'($urandom), 16'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
    if (beat.mode == MODE_CHECK) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        beat.resp_crc = response_crc(addr, beat.resp_byte0, beat.resp_byte1);
      end
      if (pick >= 60 && pick < 85) begin
        flip = $urandom_range(23);
        if (flip < 8) begin
          beat.resp_byte0[flip] = ~beat.resp_byte0[flip];
        end else if (flip < 16) begin
          beat.resp_byte1[flip-8] = ~beat.resp_byte1[flip-8];
        end else begin
          beat.resp_crc[flip-16] = ~beat.resp_crc[flip-16];
        end
      end
    end
    return beat;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_frames.push_back(predict_frame(in_data, partner_addr));
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          $error("result beat %h arrived with nothing expected", out_data);
          failures++;
        end else begin
          want = expected_frames.pop_front();
          compare_field("frame_byte0", 16'(want.frame_byte0), 16'(out_data.frame_byte0));
          compare_field("frame_byte1", 16'(want.frame_byte1), 16'(out_data.frame_byte1));
          compare_field("frame_byte2", 16'(want.frame_byte2), 16'(out_data.frame_byte2));
          compare_field("frame_crc", 16'(want.frame_crc), 16'(out_data.frame_crc));
          compare_field("read_value", want.read_value, out_data.read_value);
          compare_field("read_ok", 16'(want.read_ok), 16'(out_data.read_ok));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (pending_beats.size() != 0 || in_valid || expected_frames.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_address(input logic [7:0] value);
    logic [31:0] word;
    word       = $urandom;
    word[7:0]  = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DEVICE_ADDRESS;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    partner_addr = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    compare_field("device_address", 16'(partner_addr), 16'(prdata[7:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] addr, input int idle_pct, input int stall_pct);
    program_address(addr);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PHASE_BEATS / 2) pending_beats.push_back(random_beat(addr));
    wait_drained();
    repeat (PHASE_BEATS - PHASE_BEATS / 2) pending_beats.push_back(random_beat(addr));
    wait_drained();
  endtask

  task automatic run_all();
    logic [7:0] ok_crc;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    pending_beats.push_back(make_beat(MODE_BUILD, 8'h00, 16'h0000, 8'hFF, 8'hFF, 8'hFF));
    pending_beats.push_back(make_beat(MODE_BUILD, 8'hFF, 16'hFFFF, 8'h00, 8'h00, 8'h00));
    pending_beats.push_back(make_beat(MODE_BUILD, 8'hA5, 16'h00FF, 8'h5A, 8'hC3, 8'h3C));
    pending_beats.push_back(make_beat(MODE_BUILD, 8'h5A, 16'hFF00, 8'h12, 8'h34, 8'h56));
    pending_beats.push_back(make_beat(MODE_CHECK, 8'hFF, 16'hFFFF, 8'h00, 8'h00,
                                      response_crc(8'h00, 8'h00, 8'h00)));
    pending_beats.push_back(make_beat(MODE_CHECK, 8'h00, 16'h0000, 8'hFF, 8'hFF,
                                      response_crc(8'h00, 8'hFF, 8'hFF)));
    ok_crc = response_crc(8'h00, 8'h34, 8'h12);
    pending_beats.push_back(make_beat(MODE_CHECK, 8'h77, 16'h8001, 8'h34, 8'h12, ok_crc));
    pending_beats.push_back(make_beat(MODE_CHECK, 8'h00, 16'h0000, 8'h34, 8'h12,
                                      ok_crc ^ 8'h01));
    pending_beats.push_back(make_beat(MODE_CHECK, 8'h00, 16'h0000, 8'h34, 8'h12,
                                      ok_crc ^ 8'h80));
    pending_beats.push_back(make_beat(MODE_CHECK, 8'h00, 16'h0000, 8'h35, 8'h12, ok_crc));
    pending_beats.push_back(make_beat(MODE_CHECK, 8'hFF, 16'hFFFF, 8'h00, 8'h00, 8'h00));
    pending_beats.push_back(make_beat(MODE_CHECK, 8'h00, 16'h0000, 8'hFF, 8'hFF, 8'hFF));
    wait_drained();
    run_phase(8'hFF, 0, 0);
    run_phase(8'($urandom), 53, 0);
    run_phase(8'($urandom), 0, 53);
    run_phase(8'h00, 26, 26);
    repeat (8) @(posedge clk);
    if (expected_frames.size() != 0) begin
      $error("%0d result beats never arrived", expected_frames.size());
      failures++;
    end
  endtask

  initial begin
    fork
      run_all();
      begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $error("no beat moved for %0d cycles", QUIET_LIMIT);
        failures++;
      end
    join_any
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
